[sv/websocket_frame_receiver_macros.svh]
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define WSFR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define WSFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

[sv/wsfr_pkg.sv]
// Types and constants for the WebSocket frame receiver.
// Used by every module of the block; depends on nothing.
package wsfr_pkg;

   // Bytes at segment positions at or beyond this limit are ignored.
   localparam int RECV_LIMIT = 1023;
   localparam int SEG_POS_W  = $clog2(RECV_LIMIT + 1);
   localparam logic [SEG_POS_W-1:0] SEG_LIMIT = SEG_POS_W'(RECV_LIMIT);
   localparam logic [SEG_POS_W-1:0] SEG_LAST  = SEG_POS_W'(RECV_LIMIT - 1);

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_PONG  = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   // Control opcodes.
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Header position that marks a complete header.
   localparam logic [3:0] HDR_DONE = 4'd15;

   // Length codes that select an extended length field.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Header sizes (in bytes) before the mask key.
   localparam logic [3:0] HDR_BASE  = 4'd2;
   localparam logic [3:0] HDR_EXT16 = 4'd4;
   localparam logic [3:0] HDR_EXT64 = 4'd10;
   localparam logic [3:0] MASK_BYTES = 4'd4;

   // One received byte.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       segment_end;
   } req_type;

   // One result.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [3:0] frame_type;
      logic       last;
   } rsp_type;

   // Per-segment parser state.
   typedef struct packed {
      logic [3:0]           header_position;
      logic                 fin;
      logic [3:0]           opcode;
      logic [6:0]           length_code;
      logic                 masked_flag;
      logic [15:0]          frame_length;
      logic [31:0]          mask_key;
      logic [15:0]          payload_count;
      logic [SEG_POS_W-1:0] segment_position;
      logic                 ignore_rest;
   } frame_state_type;

endpackage

[sv/wsfr_in_reg.sv]
// Input register stage of the frame receiver.
// Depends on wsfr_pkg for the item type.
module wsfr_in_reg
   import wsfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    take,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   // The register refills whenever it is empty or its item moves on.
   assign load      = !valid_ff || take;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/wsfr_parser.sv]
// Header parser, unmasking and result decision of the frame receiver.
// Depends on wsfr_pkg and on websocket_frame_receiver_macros.svh.
`include "websocket_frame_receiver_macros.svh"

module wsfr_parser
   import wsfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    res_valid,
   output rsp_type res
);

   frame_state_type state_ff;
   frame_state_type state_in;

   logic [3:0]  p;
   logic [3:0]  ext;
   logic [3:0]  need;
   logic [7:0]  mask_byte;
   logic [15:0] cnt_next;
   logic        at_limit;
   logic        len_hit;

   // Next state and result for the byte in the input register.
   always_comb begin
      state_in  = state_ff;
      res       = '0;
      res_valid = 1'b0;
      p         = state_ff.header_position;
      ext       = HDR_BASE;
      need      = HDR_BASE;
      mask_byte = 8'd0;
      cnt_next  = state_ff.payload_count + 16'd1;
      at_limit  = (state_ff.segment_position == SEG_LAST);
      len_hit   = (cnt_next == state_ff.frame_length);

      if (state_ff.segment_position != SEG_LIMIT) begin
         state_in.segment_position = state_ff.segment_position + SEG_POS_W'(1);
         if (!state_ff.ignore_rest) begin
            if (p == HDR_DONE) begin
               // Payload byte: XOR with the mask byte chosen by the count.
               case (state_ff.payload_count[1:0])
                  2'd0: mask_byte = state_ff.mask_key[31:24];
                  2'd1: mask_byte = state_ff.mask_key[23:16];
                  2'd2: mask_byte = state_ff.mask_key[15:8];
                  default: mask_byte = state_ff.mask_key[7:0];
               endcase
               if (!state_ff.masked_flag) begin
                  mask_byte = 8'd0;
               end
               state_in.payload_count = cnt_next;
               state_in.ignore_rest   = len_hit;
               res_valid      = 1'b1;
               res.kind       = KIND_DATA;
               res.data_byte  = item.rx_byte ^ mask_byte;
               res.frame_type = state_ff.opcode;
               res.last       = len_hit || item.segment_end || at_limit;
            end else begin
               // Header byte: capture the field at this position.
               if (p == 4'd0) begin
                  state_in.fin    = item.rx_byte[7];
                  state_in.opcode = item.rx_byte[3:0];
               end else if (p == 4'd1) begin
                  state_in.masked_flag  = item.rx_byte[7];
                  state_in.length_code  = item.rx_byte[6:0];
                  state_in.frame_length = (item.rx_byte[6:0] < LEN_EXT16) ?
                                          {9'd0, item.rx_byte[6:0]} : 16'd0;
                  state_in.mask_key     = 32'd0;
               end

               if (state_in.length_code == LEN_EXT16) begin
                  ext = HDR_EXT16;
               end else if (state_in.length_code == LEN_EXT64) begin
                  ext = HDR_EXT64;
               end

               if (p >= 4'd2) begin
                  if (state_in.length_code == LEN_EXT16 && p < 4'd4) begin
                     state_in.frame_length = {state_ff.frame_length[7:0],
                                              item.rx_byte};
                  end else if (state_in.masked_flag && p >= ext &&
                               p < ext + MASK_BYTES) begin
                     state_in.mask_key = {state_ff.mask_key[23:0], item.rx_byte};
                  end
               end

               state_in.header_position = p + 4'd1;
               need = ext + (state_in.masked_flag ? MASK_BYTES : 4'd0);

               // Header complete: act on the opcode.
               if (p >= 4'd1 && state_in.header_position == need) begin
                  state_in.header_position = HDR_DONE;
                  res.frame_type = state_in.opcode;
                  if (state_in.opcode == OP_PING) begin
                     state_in.ignore_rest = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = KIND_PONG;
                  end else if (state_in.opcode == OP_PONG) begin
                     state_in.ignore_rest = 1'b1;
                  end else if (state_in.opcode == OP_CLOSE) begin
                     state_in.ignore_rest = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = KIND_CLOSE;
                  end else if (!state_in.fin) begin
                     state_in.ignore_rest = 1'b1;
                  end else if (state_in.frame_length == 16'd0) begin
                     state_in.ignore_rest = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = KIND_EMPTY;
                     res.last  = 1'b1;
                  end
               end
            end
         end
      end

      // The end of a segment returns all frame state to reset.
      if (item.segment_end) begin
         state_in = '0;
      end
   end

   // State advances only when the byte is actually consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   // A header never stops one byte short of the done marker.
   `WSFR_ASSERT_NOW(a_hdr_pos_gap, clock, reset, 1'b1, state_ff.header_position != 4'd14)
   // Payload bytes are only produced once the header is complete.
   `WSFR_ASSERT_NOW(a_data_after_hdr, clock, reset, res_valid && res.kind == KIND_DATA,
                    state_ff.header_position == HDR_DONE)
   // Ignored bytes never produce a result.
   `WSFR_ASSERT_NOW(a_ignore_quiet, clock, reset, state_ff.ignore_rest, !res_valid)
   // A consumed segment end leaves the segment counter cleared.
   `WSFR_ASSERT_NEXT(a_seg_clear, clock, reset, step && item.segment_end,
                     state_ff.segment_position == '0)

endmodule

[sv/websocket_frame_receiver.sv]
// WebSocket frame receiver: one segment in byte by byte, results out.
// Depends on wsfr_pkg, wsfr_in_reg and wsfr_parser.
//
// The block takes one received byte per clock while the result register can
// take a result; rsp_stall holds it back through req_stall. A byte's result,
// if any, passes from the input register through the combinational parser
// into the result register (one input register, one result register). The
// parser updates its state once for each registered byte that is consumed.
// Each segment carries one frame; its header is parsed, the mask key
// collected, and payload bytes of final data frames are unmasked and
// delivered, with last set on the final byte. Pings request a pong, closes
// request a close, pongs and non-final frames are dropped, and an empty final
// frame yields one empty-message result. Bytes at segment position
// RECV_LIMIT and later are ignored, and all frame state clears after the
// byte that carries segment_end.
module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    take;
   logic    item_valid;
   req_type item;
   logic    res_valid;
   rsp_type res;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;

   // The result register frees up when empty or when its item is taken.
   assign take         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = take ? (item_valid && res_valid) : rsp_valid_ff;

   wsfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   wsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (item_valid && take),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
